// ===== rtl/rv64d_pkg.sv =====
`default_nettype none
// ============================================================================
// rv64d_pkg
// Shared types and constants of the radix-64 block value decoder: state
// encoding, configuration register indexes and the interface structs
// between the character front end, the shared arithmetic unit and the top.
// ============================================================================
package rv64d_pkg;

    localparam int ACC_W    = 30;   // five six-bit digits
    localparam int OUT_W    = 48;
    localparam int QUO_W    = 62;   // quotient of a 30-bit value shifted up by 32
    localparam int CNT_W    = 6;
    localparam int MUL_STEPS = 16;  // one step per bit of the integer scale
    localparam int DIV_STEPS = 62;  // one step per quotient bit

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

    typedef enum logic [2:0] {
        CFG_DIGITS = 3'd0,
        CFG_WORDS  = 3'd1,
        CFG_MODE   = 3'd2,
        CFG_SCALE  = 3'd3,
        CFG_OFFSET = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_FINISH
    } dec_state_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ACC_W-1:0] value;
    } front_evt_t;

    typedef struct packed {
        logic             start;
        logic             div_mode;
        logic [ACC_W-1:0] operand;
        logic [31:0]      divisor;
        logic [15:0]      multiplier;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rv64d_front.sv =====
`default_nettype none
// ============================================================================
// rv64d_front
// Character front end: maps each character to a six-bit digit, packs digits
// into values and keeps the line, block and skip state. Flags a completed
// value in the same cycle as the transfer of its last character.
// ============================================================================
module rv64d_front
    import rv64d_pkg::*;
#(
    parameter int LINE_CHARS = 78,
    parameter int MAX_DIGITS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  char_in,
    input  logic [2:0]  digits_cfg,
    input  logic [23:0] words_cfg,
    output front_evt_t  evt
);

    localparam logic [6:0] PER_LINE_1 = 7'(LINE_CHARS / 1);
    localparam logic [6:0] PER_LINE_2 = 7'(LINE_CHARS / 2);
    localparam logic [6:0] PER_LINE_3 = 7'(LINE_CHARS / 3);
    localparam logic [6:0] PER_LINE_4 = 7'(LINE_CHARS / 4);
    localparam logic [6:0] PER_LINE_5 = 7'(LINE_CHARS / 5);

    function automatic logic [5:0] sym_value(input logic [7:0] c);
        logic [5:0] d;
        d = 6'd0;
        if (c >= 8'd48 && c <= 8'd57)
        begin
            d = 6'(c - 8'd48);
        end
        else if (c >= 8'd65 && c <= 8'd90)
        begin
            d = 6'(c - 8'd55);
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            d = 6'(c - 8'd61);
        end
        else if (c == 8'd123)
        begin
            d = 6'd62;
        end
        else if (c == 8'd124)
        begin
            d = 6'd63;
        end
        return d;
    endfunction

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]       dcnt_reg, dcnt_next;
    logic [6:0]       line_reg, line_next;
    logic [23:0]      block_reg, block_next;
    logic             skip_reg, skip_next;

    logic [2:0]       digits;
    logic [23:0]      words;
    logic [6:0]       per_line;
    logic [ACC_W-1:0] acc_shift;
    logic [2:0]       dcnt_inc;
    logic [6:0]       line_inc;
    logic [23:0]      block_inc;

    always_comb
    begin
        priority if (digits_cfg == 3'd0)
        begin
            digits = 3'd1;
        end
        else if (digits_cfg > 3'(MAX_DIGITS))
        begin
            digits = 3'(MAX_DIGITS);
        end
        else
        begin
            digits = digits_cfg;
        end
    end

    assign words = (words_cfg == 24'd0) ? 24'd1 : words_cfg;

    always_comb
    begin
        unique case (digits)
            3'd1:    per_line = PER_LINE_1;
            3'd2:    per_line = PER_LINE_2;
            3'd3:    per_line = PER_LINE_3;
            3'd4:    per_line = PER_LINE_4;
            default: per_line = PER_LINE_5;
        endcase
    end

    assign acc_shift = {acc_reg[ACC_W-7:0], sym_value(char_in)};
    assign dcnt_inc  = dcnt_reg + 3'd1;
    assign line_inc  = line_reg + 7'd1;
    assign block_inc = block_reg + 24'd1;

    always_comb
    begin
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        line_next  = line_reg;
        block_next = block_reg;
        skip_next  = skip_reg;
        evt        = '0;
        evt.value  = acc_shift;
        if (step)
        begin
            priority if (char_in == CHAR_NEWLINE)
            begin
                skip_next = 1'b0;
                line_next = 7'd0;
                dcnt_next = 3'd0;
                acc_next  = '0;
            end
            else if (skip_reg)
            begin
                skip_next = 1'b1;
            end
            else if (dcnt_inc < digits)
            begin
                acc_next  = acc_shift;
                dcnt_next = dcnt_inc;
            end
            else
            begin
                evt.emit   = 1'b1;
                acc_next   = '0;
                dcnt_next  = 3'd0;
                line_next  = line_inc;
                block_next = block_inc;
                if (block_inc >= words)
                begin
                    evt.last   = 1'b1;
                    block_next = 24'd0;
                    line_next  = 7'd0;
                    skip_next  = 1'b1;
                end
                else if (line_inc >= per_line)
                begin
                    line_next = 7'd0;
                    skip_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            dcnt_reg  <= 3'd0;
            line_reg  <= 7'd0;
            block_reg <= 24'd0;
            skip_reg  <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            line_reg  <= line_next;
            block_reg <= block_next;
            skip_reg  <= skip_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rv64d_arith.sv =====
`default_nettype none
// ============================================================================
// rv64d_arith
// Shared add/subtract unit under a step counter. Integer mode runs a
// shift-add multiply over the sixteen integer bits of the scale; fraction
// mode runs a restoring divide that produces one quotient bit per step.
// ============================================================================
module rv64d_arith
    import rv64d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  arith_req_t       req,
    output arith_stat_t      stat,
    output logic [QUO_W-1:0] result
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             div_reg, div_next;
    logic [32:0]      rem_reg, rem_next;
    logic [QUO_W-1:0] nq_reg, nq_next;
    logic [31:0]      opnd_reg, opnd_next;

    logic [32:0]      rem_sh;
    logic [33:0]      add_a;
    logic [33:0]      add_b;
    logic [33:0]      sum;
    logic [CNT_W-1:0] last_step;

    assign rem_sh    = {rem_reg[31:0], nq_reg[QUO_W-1]};
    assign add_a     = div_reg ? {1'b0, rem_sh} : {1'b0, rem_reg};
    assign add_b     = (div_reg || nq_reg[0]) ? {2'b00, opnd_reg} : 34'd0;
    // One adder serves both operations: subtract for the divide, add otherwise.
    assign sum       = add_a + (add_b ^ {34{div_reg}}) + {33'd0, div_reg};
    assign last_step = div_reg ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == last_step);
    assign result    = div_reg ? nq_reg
                               : {16'd0, rem_reg[ACC_W-1:0], nq_reg[15:0]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        opnd_next = opnd_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = req.div_mode;
            rem_next  = 33'd0;
            if (req.div_mode)
            begin
                opnd_next = req.divisor;
                nq_next   = {req.operand, 32'd0};
            end
            else
            begin
                opnd_next = {2'b00, req.operand};
                nq_next   = {46'd0, req.multiplier};
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (stat.done)
            begin
                busy_next = 1'b0;
            end
            if (div_reg)
            begin
                // A clear sign bit means the remainder covered the divisor.
                if (!sum[33])
                begin
                    rem_next = sum[32:0];
                end
                else
                begin
                    rem_next = rem_sh;
                end
                nq_next = {nq_reg[QUO_W-2:0], ~sum[33]};
            end
            else
            begin
                rem_next = sum[33:1];
                nq_next  = {nq_reg[QUO_W-1:16], sum[0], nq_reg[15:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nq_reg   <= nq_next;
        opnd_reg <= opnd_next;
    end

endmodule
`default_nettype wire

// ===== rtl/radix64_block_value_decoder.sv =====
`default_nettype none
// ============================================================================
// radix64_block_value_decoder
// Decodes a radix-64 text stream into packed integer values, then scales
// and offsets each value in integer or Q16.16 fraction mode.
// ============================================================================
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------
//  input   | in_valid / in_ready   | char_in
//  output  | out_valid / out_ready | value_out, last_value
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A character that completes no value leaves input ready.
//  A character that completes a value holds off input while the 16
//  multiply steps in integer mode or 62 divide steps in fraction mode of
//  the shared add/subtract unit run (none with a zero divisor) and until
//  the output register is loaded.
//  The output register lets input continue while a result waits; a second
//  value waits in the final step until that register is free.
//  Reset is asynchronous and restores the default register settings.
//
module radix64_block_value_decoder
    import rv64d_pkg::*;
#(
    parameter int LINE_CHARS = 78,
    parameter int MAX_DIGITS = 5
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              char_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] value_out,
    output logic                    last_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data
);

    dec_state_t state_reg, state_next;

    logic [2:0]  digits_reg;
    logic [23:0] words_reg;
    logic        mode_reg;
    logic [31:0] scale_reg;
    logic [31:0] offset_reg;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] value_reg;
    logic             last_reg;
    logic             last_pend_reg;
    logic             dz_reg;

    front_evt_t       front_evt;
    arith_req_t       arith_req;
    arith_stat_t      arith_stat;
    logic [QUO_W-1:0] arith_result;

    logic        in_accept;
    logic        div_zero;
    logic        out_free;
    logic        load_out;
    logic [16:0] ioff;
    logic signed [63:0] base64;
    logic signed [63:0] sub64;
    logic signed [63:0] diff64;
    logic [OUT_W-1:0]   clamped;

    assign in_accept = in_valid && in_ready;
    assign div_zero  = mode_reg && (scale_reg == 32'd0);
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    rv64d_front #(
        .LINE_CHARS (LINE_CHARS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_accept),
        .char_in    (char_in),
        .digits_cfg (digits_reg),
        .words_cfg  (words_reg),
        .evt        (front_evt)
    );

    rv64d_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .stat   (arith_stat),
        .result (arith_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && front_evt.emit)
                begin
                    state_next = div_zero ? ST_FINISH : ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (arith_stat.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready             = (state_reg == ST_IDLE);
        load_out             = (state_reg == ST_FINISH) && out_free;
        arith_req.start      = (state_reg == ST_IDLE) && in_accept && front_evt.emit
                               && !div_zero;
        arith_req.div_mode   = mode_reg;
        arith_req.operand    = front_evt.value;
        arith_req.divisor    = scale_reg;
        arith_req.multiplier = scale_reg[31:16];
    end

    // Integer offset truncates toward zero: negative values with a fraction
    // round up by one.
    assign ioff   = {offset_reg[31], offset_reg[31:16]}
                    + {16'd0, offset_reg[31] && (offset_reg[15:0] != 16'd0)};
    assign base64 = dz_reg ? OUT_MAX : {2'b00, arith_result};
    assign sub64  = mode_reg ? {{32{offset_reg[31]}}, offset_reg}
                             : {{47{ioff[16]}}, ioff};
    assign diff64 = base64 - sub64;

    always_comb
    begin
        priority if (diff64 > OUT_MAX)
        begin
            clamped = OUT_MAX[OUT_W-1:0];
        end
        else if (diff64 < OUT_MIN)
        begin
            clamped = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            clamped = diff64[OUT_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dz_reg        <= 1'b0;
            digits_reg    <= 3'd1;
            words_reg     <= 24'd1;
            mode_reg      <= 1'b0;
            scale_reg     <= 32'd65536;
            offset_reg    <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_accept && front_evt.emit)
            begin
                dz_reg <= div_zero;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DIGITS: digits_reg <= cfg_data[2:0];
                    CFG_WORDS:  words_reg  <= cfg_data[23:0];
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    CFG_SCALE:  scale_reg  <= cfg_data;
                    CFG_OFFSET: offset_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && front_evt.emit)
        begin
            last_pend_reg <= front_evt.last;
        end
        if (load_out)
        begin
            value_reg <= clamped;
            last_reg  <= last_pend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_out  = value_reg;
    assign last_value = last_reg;

`ifndef NO_ASSERTIONS
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        arith_stat.done |-> (state_reg == ST_CALC))
        else $error("arithmetic unit finished outside the calculation state");

    a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        arith_stat.busy |-> !in_ready)
        else $error("input taken while the arithmetic unit is busy");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        arith_req.start |=> (arith_stat.busy && state_reg == ST_CALC))
        else $error("started value is not being calculated");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("finished value did not reach the output register");
`endif

endmodule
`default_nettype wire
